// File: rtl/core/owfm_pkg.sv
`default_nettype none

package owfm_pkg;

	localparam int ID_W     = 16;
	localparam int YEAR_W   = 12;
	localparam int ENTRY_W  = ID_W + YEAR_W;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 4;

	// quotient bits resolved per divider cycle
	localparam int DIV_BITS  = 3;
	localparam int DIV_STEPS = YEAR_W / DIV_BITS;
	localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERWRITE = 2'd1,
		STATUS_EMPTY     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/overwrite_fifo_with_mean_unit.sv
`default_nettype none

// circular record fifo that drops its oldest entry when full and reports the mean year
// input channel: a request (req_type, record_id, record_year) transfers on a rising
//   edge with start high and busy low; busy stays high until the result is issued
// result channel: status, out_id, out_year, mean_year and fill_count hold one result,
//   valid for exactly one cycle while done is high; the receiver cannot stall it
// timing: the entry at the head is read from the entry memory at the transfer edge,
//   the next cycle updates pointers, count, year sum and writes the memory, then the
//   mean is found by a divider that resolves 3 quotient bits per cycle
// done and mean_year are registered from the last divider step
// requests are not taken while busy is high; a new request may transfer in the cycle
//   that done is high
// the entry memory has one write port and one registered read port; reads and
//   writes fall in different cycles of a request, so no forwarding is needed
// reset: the fifo is empty, both pointers are zero and no result is pending; the
//   entry memory is not cleared, only entries written since are ever used
module overwrite_fifo_with_mean_unit #(
	parameter int CAPACITY = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              req_type,
	input  wire logic [owfm_pkg::ID_W-1:0]         record_id,
	input  wire logic [owfm_pkg::YEAR_W-1:0]       record_year,
	output logic                                   done,
	output logic [owfm_pkg::STATUS_W-1:0]          status,
	output logic [owfm_pkg::ID_W-1:0]              out_id,
	output logic [owfm_pkg::YEAR_W-1:0]            out_year,
	output logic [owfm_pkg::YEAR_W-1:0]            mean_year,
	output logic [owfm_pkg::FILL_W-1:0]            fill_count
);

	localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = owfm_pkg::YEAR_W + CNT_W;
	localparam int YW    = owfm_pkg::YEAR_W;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [owfm_pkg::DIV_CNT_W-1:0] DIV_LAST =
		owfm_pkg::DIV_CNT_W'(owfm_pkg::DIV_STEPS - 1);

	owfm_pkg::state_t state_q, state_d;

	// control
	logic mem_re, upd_en, div_en, div_last;
	logic accept;

	// fifo state
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;

	// request registers
	owfm_pkg::req_t               req_q;
	logic [owfm_pkg::ID_W-1:0]    id_q;
	logic [YW-1:0]                year_q;

	// entry memory
	logic [owfm_pkg::ENTRY_W-1:0] mem [CAPACITY];
	logic [owfm_pkg::ENTRY_W-1:0] rd_entry_q;
	logic                         mem_we;

	// update results
	logic [PTR_W-1:0]       head_d, tail_d;
	logic [CNT_W-1:0]       count_d;
	logic [SUM_W-1:0]       sum_d;
	owfm_pkg::status_t      status_d;
	logic [owfm_pkg::ID_W-1:0] rid_d;
	logic [YW-1:0]          ryear_d;

	// divider
	logic [CNT_W-1:0]               div_rem_q, div_rem_d;
	logic [YW-1:0]                  div_quo_q, div_quo_d;
	logic [CNT_W-1:0]               div_den_q;
	logic [owfm_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// result registers
	logic                      done_q;
	owfm_pkg::status_t         status_q;
	logic [owfm_pkg::ID_W-1:0] out_id_q;
	logic [YW-1:0]             out_year_q;
	logic [YW-1:0]             mean_q;
	logic [CNT_W-1:0]          fill_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	assign accept = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			owfm_pkg::ST_IDLE: begin
				if (start) begin
					state_d = owfm_pkg::ST_UPDATE;
				end
			end
			owfm_pkg::ST_UPDATE: begin
				state_d = owfm_pkg::ST_DIV;
			end
			owfm_pkg::ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = owfm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = owfm_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		busy     = 1'b1;
		mem_re   = 1'b0;
		upd_en   = 1'b0;
		div_en   = 1'b0;
		div_last = 1'b0;
		case (state_q)
			owfm_pkg::ST_IDLE: begin
				busy   = 1'b0;
				mem_re = start;
			end
			owfm_pkg::ST_UPDATE: begin
				upd_en = 1'b1;
			end
			owfm_pkg::ST_DIV: begin
				div_en   = 1'b1;
				div_last = (div_cnt_q == DIV_LAST);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= owfm_pkg::req_t'(req_type);
			id_q   <= record_id;
			year_q <= record_year;
		end
	end

	// entry memory: head is read at the transfer edge, tail written in the update cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= {id_q, year_q};
		end
		if (mem_re) begin
			rd_entry_q <= mem[head_q];
		end
	end

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		sum_d    = sum_q;
		status_d = owfm_pkg::STATUS_OK;
		rid_d    = '0;
		ryear_d  = '0;
		mem_we   = 1'b0;
		if (req_q == owfm_pkg::REQ_INSERT) begin
			mem_we = upd_en;
			tail_d = ptr_next(tail_q);
			if (count_q == CNT_FULL) begin
				// drop the oldest entry first
				sum_d    = sum_q - SUM_W'(rd_entry_q[YW-1:0]) + SUM_W'(year_q);
				head_d   = ptr_next(head_q);
				status_d = owfm_pkg::STATUS_OVERWRITE;
			end else begin
				sum_d   = sum_q + SUM_W'(year_q);
				count_d = count_q + CNT_W'(1);
			end
		end else if (count_q == '0) begin
			status_d = owfm_pkg::STATUS_EMPTY;
		end else begin
			rid_d   = rd_entry_q[owfm_pkg::ENTRY_W-1:YW];
			ryear_d = rd_entry_q[YW-1:0];
			sum_d   = sum_q - SUM_W'(rd_entry_q[YW-1:0]);
			head_d  = ptr_next(head_q);
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (upd_en) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	// long division of the sum by the count; the quotient fits the year width, so the
	// upper sum bits seed the remainder and the low bits shift through the quotient
	always_comb begin
		logic [CNT_W:0]  r;
		logic [YW-1:0]   q;
		r = {1'b0, div_rem_q};
		q = div_quo_q;
		for (int j = 0; j < owfm_pkg::DIV_BITS; j++) begin
			r = {r[CNT_W-1:0], q[YW-1]};
			q = {q[YW-2:0], 1'b0};
			if (r >= {1'b0, div_den_q}) begin
				r    = r - {1'b0, div_den_q};
				q[0] = 1'b1;
			end
		end
		div_rem_d = r[CNT_W-1:0];
		div_quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (upd_en) begin
			div_cnt_q <= '0;
		end else if (div_en) begin
			div_cnt_q <= div_cnt_q + owfm_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			div_rem_q <= sum_d[SUM_W-1:YW];
			div_quo_q <= sum_d[YW-1:0];
			div_den_q <= count_d;
		end else if (div_en) begin
			div_rem_q <= div_rem_d;
			div_quo_q <= div_quo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_last;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			status_q   <= status_d;
			out_id_q   <= rid_d;
			out_year_q <= ryear_d;
			fill_q     <= count_d;
		end
		if (div_last) begin
			// empty fifo reports a mean of zero
			mean_q <= (div_den_q == '0) ? '0 : div_quo_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_id     = out_id_q;
	assign out_year   = out_year_q;
	assign mean_year  = mean_q;
	assign fill_count = owfm_pkg::FILL_W'(fill_q);

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a request transfer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count exceeds capacity");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == owfm_pkg::STATUS_EMPTY) |->
		(fill_count == '0 && out_id == '0 && mean_year == '0))
		else $error("remove on empty reported a non-empty result");
`endif

endmodule

`default_nettype wire
